@@ rtl/core/mspg_pkg.sv @@
// shared types, constants and register codes of the step pulse generator
package mspg_pkg;

    // default sizing
    localparam int AXES_DEF        = 5;
    localparam int COUNT_WIDTH_DEF = 24;

    // field widths fixed by the interface
    localparam int POS_W    = 32;
    localparam int SPM_W    = 24;
    localparam int ACT_W    = 2;
    localparam int AXIS_W   = 3;
    localparam int SHOW_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    // reset values of the settings
    localparam logic [SPM_W-1:0]  SPM_RESET = 24'd256;
    localparam logic [SHOW_W-1:0] POL_RESET = 5'd4;

    // index of the z axis for bend mode
    localparam int Z_AXIS = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD_TGT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_POS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPM_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPM_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEND     = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic apply;
        logic start_clr;
        logic calc_dist;
        logic calc_prod;
        logic wb;
        logic set_run;
        logic sel_axis;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             div_done;
        logic             last_axis;
    } t_sts;

endpackage

@@ rtl/core/mspg_div.sv @@
// restoring divider, one quotient bit per cycle
module mspg_div
    import mspg_pkg::*;
#(
    parameter int QW = SPM_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_num,
    input  logic [QW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);

    localparam int CW = $clog2(QW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW:0]   r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [QW-1:0] r_den, n_den;
    logic [QW:0]   trial;

    // one shift and subtract step
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        trial  = {r_rem[QW-1:0], r_quo[QW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(QW);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = trial - {1'b0, r_den};
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operands need no reset
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ rtl/core/mspg_ctrl.sv @@
// sequencing state machine of the step pulse generator
module mspg_ctrl
    import mspg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIST = 3'd2;
    localparam logic [2:0] S_PROD = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_free;

    assign out_free = !r_ovalid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.action == ACT_START) begin
                    o_cmd.start_clr = 1'b1;
                    n_state = S_DIST;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DIST: begin
                o_cmd.calc_dist = 1'b1;
                n_state = S_PROD;
            end
            S_PROD: begin
                o_cmd.calc_prod = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (i_sts.last_axis) begin
                    o_cmd.set_run = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIST;
                end
            end
            S_OUT: begin
                o_cmd.sel_axis = 1'b1;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

`ifndef NO_ASSERTIONS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> out_free)
        else $error("result register overwritten");

    // one result per accepted request
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && out_free |=> o_out_valid)
        else $error("result lost");

    // no request accepted during the per-axis sequence
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVW) |-> !o_in_ready)
        else $error("request accepted while busy");
`endif

endmodule

@@ rtl/core/mspg_dp.sv @@
// axis state, settings, start arithmetic and tick update
module mspg_dp
    import mspg_pkg::*;
#(
    parameter int AXES        = AXES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SPM_W-1:0]       i_cfg_data,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int CW = COUNT_WIDTH;
    localparam int PW = POS_W + SPM_W;
    localparam logic [POS_W:0] STEP_MAX = (POS_W+1)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [PW:0]    HALF_RND = (PW+1)'(64'd1 << 23);
    localparam logic [SPM_W-1:0] HALF_NUM = SPM_W'(64'd1 << 23);

    // settings
    logic [SPM_W-1:0]  r_spm [AXES];
    logic [SHOW_W-1:0] r_pol;
    logic              r_bend;

    // captured request
    logic [ACT_W-1:0]  r_action;
    logic [AXIS_W-1:0] r_axis;
    logic [POS_W-1:0]  r_val;

    // axis state
    logic signed [POS_W-1:0] r_tgt [AXES];
    logic signed [POS_W-1:0] r_pos [AXES];
    logic signed [POS_W-1:0] r_inc [AXES];
    logic [CW-1:0]           r_lim [AXES];
    logic [CW-1:0]           r_cnt [AXES];
    logic [AXES-1:0]         r_pulse, r_dir, r_reached;
    logic                    r_run, r_zf;

    // start sequence
    logic [AW-1:0]      r_idx;
    logic [POS_W-1:0]   r_dist;
    logic               r_back;
    logic [SPM_W-1:0]   r_s;
    logic [PW-1:0]      r_prod;
    logic [OUT_TDATA_W-1:0] r_out;

    logic              axis_ok;
    logic [AW-1:0]     rd_idx;
    logic signed [POS_W:0] diff;
    logic              diff_back;
    logic [POS_W-1:0]  diff_mag;
    logic [PW:0]       prod_rnd;
    logic [POS_W:0]    steps;
    logic [POS_W:0]    steps_sat;
    logic [CW-1:0]     lim_new;
    logic [SPM_W-1:0]  quo;
    logic [SPM_W-1:0]  mag;
    logic signed [POS_W-1:0] inc_new;
    logic              div_done;
    logic [AXES+SHOW_W-1:0] pol_ext;

    // tick results per axis
    logic signed [POS_W-1:0] t_pos [AXES];
    logic [CW-1:0]           t_cnt [AXES];
    logic [AXES-1:0]         t_pulse, t_reached;
    logic                    t_run, t_zf;

    assign axis_ok = ({1'b0, r_axis} < (AXIS_W+1)'(AXES));
    assign rd_idx  = i_cmd.sel_axis ? r_axis[AW-1:0] : r_idx;
    assign pol_ext = {{AXES{1'b0}}, r_pol};

    // distance and direction of the axis in turn
    assign diff      = {r_tgt[rd_idx][POS_W-1], r_tgt[rd_idx]}
                     - {r_pos[rd_idx][POS_W-1], r_pos[rd_idx]};
    assign diff_back = diff[POS_W];
    assign diff_mag  = diff_back ? POS_W'(-diff) : diff[POS_W-1:0];

    // rounded, saturated step count
    assign prod_rnd  = {1'b0, r_prod} + HALF_RND;
    assign steps     = prod_rnd[PW:24];
    assign steps_sat = (steps > STEP_MAX) ? STEP_MAX : steps;
    assign lim_new   = {steps_sat[CW-2:0], 1'b0};
    assign mag       = (r_s == '0) ? '0 : quo;
    assign inc_new   = r_back ? -$signed({{(POS_W-SPM_W){1'b0}}, mag})
                              : $signed({{(POS_W-SPM_W){1'b0}}, mag});

    mspg_div #(.QW(SPM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.calc_prod),
        .i_num   (HALF_NUM + {1'b0, r_s[SPM_W-1:1]}),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // one tick over all axes, each with its own adder
    always_comb begin
        logic signed [POS_W:0] np;
        t_pulse   = r_pulse;
        t_reached = r_reached;
        t_run     = r_run;
        t_zf      = r_zf;
        np        = '0;
        for (int i = 0; i < AXES; i++) begin
            t_pos[i] = r_pos[i];
            t_cnt[i] = r_cnt[i];
            if (r_cnt[i] < r_lim[i]) begin
                np = {r_pos[i][POS_W-1], r_pos[i]} + {r_inc[i][POS_W-1], r_inc[i]};
                if (np[POS_W] != np[POS_W-1]) begin
                    t_pos[i] = np[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                         : {1'b0, {(POS_W-1){1'b1}}};
                end else begin
                    t_pos[i] = np[POS_W-1:0];
                end
                t_cnt[i]   = r_cnt[i] + 1'b1;
                t_pulse[i] = !r_pulse[i];
            end
            if (t_cnt[i] >= r_lim[i]) begin
                t_reached[i] = 1'b1;
                if (i == Z_AXIS && r_bend) begin
                    t_zf  = 1'b1;
                    t_run = 1'b0;
                end
            end
        end
        if (&t_reached) begin
            t_run = 1'b0;
        end
    end

    // settings port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_spm[i] <= SPM_RESET;
            end
            r_pol  <= POL_RESET;
            r_bend <= 1'b0;
        end else if (i_cfg_we) begin
            for (int i = 0; i < AXES; i++) begin
                if (i <= int'(REG_SPM_B) && i_cfg_index == CFG_IDX_W'(i)) begin
                    r_spm[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == REG_POLARITY) begin
                r_pol <= i_cfg_data[SHOW_W-1:0];
            end
            if (i_cfg_index == REG_BEND) begin
                r_bend <= i_cfg_data[0];
            end
        end
    end

    // axis state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_tgt[i] <= '0;
                r_pos[i] <= '0;
                r_inc[i] <= '0;
                r_lim[i] <= '0;
                r_cnt[i] <= '0;
            end
            r_pulse   <= '0;
            r_dir     <= '0;
            r_reached <= '0;
            r_run     <= 1'b0;
            r_zf      <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.apply) begin
                unique case (r_action)
                    ACT_LOAD_TGT: begin
                        if (axis_ok) begin
                            r_tgt[r_axis[AW-1:0]] <= r_val;
                        end
                    end
                    ACT_LOAD_POS: begin
                        if (axis_ok) begin
                            r_pos[r_axis[AW-1:0]] <= r_val;
                        end
                    end
                    ACT_TICK: begin
                        if (r_run) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_pos[i] <= t_pos[i];
                                r_cnt[i] <= t_cnt[i];
                            end
                            r_pulse   <= t_pulse;
                            r_reached <= t_reached;
                            r_run     <= t_run;
                            r_zf      <= t_zf;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start_clr) begin
                r_reached <= '0;
                r_zf      <= 1'b0;
                r_dir     <= '0;
                r_idx     <= '0;
            end
            if (i_cmd.wb) begin
                r_lim[r_idx] <= lim_new;
                r_cnt[r_idx] <= '0;
                r_inc[r_idx] <= inc_new;
                r_dir[r_idx] <= r_back ^ pol_ext[r_idx];
                r_idx        <= r_idx + 1'b1;
            end
            if (i_cmd.set_run) begin
                r_run <= 1'b1;
            end
        end
    end

    // request capture, start operands and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_in_data[ACT_W-1:0];
            r_axis   <= i_in_data[ACT_W+AXIS_W-1:ACT_W];
            r_val    <= i_in_data[ACT_W+AXIS_W+POS_W-1:ACT_W+AXIS_W];
        end
        if (i_cmd.calc_dist) begin
            r_dist <= diff_mag;
            r_back <= (diff_back == 1'b0) ? 1'b0 : 1'b1;
            r_s    <= r_spm[rd_idx];
        end
        if (i_cmd.calc_prod) begin
            r_prod <= PW'(r_dist) * PW'(r_s);
        end
        if (i_cmd.out_load) begin
            r_out <= {{(OUT_TDATA_W-POS_W-2-3*SHOW_W){1'b0}},
                      axis_ok ? r_pos[rd_idx] : {POS_W{1'b0}},
                      r_zf, r_run,
                      SHOW_W'({{SHOW_W{1'b0}}, r_reached}),
                      SHOW_W'({{SHOW_W{1'b0}}, r_dir}),
                      SHOW_W'({{SHOW_W{1'b0}}, r_pulse})};
        end
    end

    assign o_out_data       = r_out;
    assign o_sts.action     = r_action;
    assign o_sts.div_done   = div_done;
    assign o_sts.last_axis  = (r_idx == AW'(AXES - 1));

`ifndef NO_ASSERTIONS
    // z done only comes from bend mode
    a_zf_bend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_zf) |-> $past(r_bend))
        else $error("z done set outside bend mode");

    // a start clears the reached flags
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_clr |=> (r_reached == '0) && !r_zf)
        else $error("start left flags set");

    // running with all axes reached does not survive a tick
    a_run_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && (r_action == ACT_TICK) && r_run && (&t_reached) |=> !r_run)
        else $error("move kept running after all axes reached");
`endif

endmodule

@@ rtl/core/multi_axis_step_pulse_generator.sv @@
// Five-axis step/direction generator, one request at a time.
// Load and tick: IDLE captures, EXEC applies, OUT registers the result.
// Start: after EXEC, each axis in turn passes DIST, PROD, DIVW and WB,
// around one pass of the shared 24-step restoring divider, then OUT.
// One result per request; a new request is taken while a result waits.
// Synchronous active-low reset clears all axis state and loads default settings.
module multi_axis_step_pulse_generator
    import mspg_pkg::*;
#(
    parameter int AXES        = AXES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // action[1:0], axis[4:2], position_value[36:5]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pulse_levels[4:0], dir_levels[9:5], reached_flags[14:10], running[15],
    // z_done[16], position_out[48:17]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SPM_W-1:0]       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    mspg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // axis datapath
    mspg_dp #(
        .AXES        (AXES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

@@ dv/multi_axis_step_pulse_generator_test.sv @@
// testbench of the step pulse generator: directed table, random requests, checked per result
module multi_axis_step_pulse_generator_test;
    import mspg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pos;
        logic        zd;
        logic        run;
        logic [4:0]  reached;
        logic [4:0]  dirs;
        logic [4:0]  pulses;
    } t_levels;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [AXIS_W-1:0] ax;
        logic [31:0]       val;
        bit                known;
        t_levels           lv;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SPM_W-1:0] i_cfg_data = '0;

    multi_axis_step_pulse_generator dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // mirrored machine state
    logic [23:0] spm [5];
    logic [4:0]  pol;
    logic        bend;
    logic [31:0] tgt [5];
    logic [31:0] posn [5];
    logic [31:0] inc [5];
    logic [24:0] lim [5];
    logic [24:0] cnt [5];
    logic [4:0]  pulses, dirs, reached;
    logic        run, zd;

    t_levels expected_levels [$];
    int errors = 0;
    int results_seen = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        longint s;
        s = longint'($signed(a)) + longint'($signed(b));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    // apply one request to the mirrored state and return the levels
    function automatic t_levels step_axes(logic [1:0] act, logic [2:0] ax, logic [31:0] v);
        t_levels r;
        longint p, t, d;
        logic [63:0] steps, mag;
        bit back, ok;
        ok = ax < 5;
        case (act)
            ACT_LOAD_TGT: if (ok) tgt[ax] = v;
            ACT_LOAD_POS: if (ok) posn[ax] = v;
            ACT_START: begin
                reached = 0; zd = 0; dirs = 0;
                for (int i = 0; i < 5; i++) begin
                    p = $signed(posn[i]);
                    t = $signed(tgt[i]);
                    back = p > t;
                    d = back ? p - t : t - p;
                    steps = (64'(d) * spm[i] + 64'h800000) >> 24;
                    if (steps > 64'h7FFFFF) steps = 64'h7FFFFF;
                    lim[i] = 25'(2 * steps);
                    cnt[i] = 0;
                    mag = spm[i] != 0 ? (64'h800000 + spm[i] / 2) / spm[i] : 0;
                    inc[i] = back ? -mag[31:0] : mag[31:0];
                    dirs[i] = back ^ pol[i];
                end
                run = 1;
            end
            ACT_TICK: if (run) begin
                for (int i = 0; i < 5; i++) begin
                    if (cnt[i] < lim[i]) begin
                        posn[i] = sat_add(posn[i], inc[i]);
                        cnt[i]++;
                        pulses[i] = ~pulses[i];
                    end
                    if (cnt[i] >= lim[i]) begin
                        reached[i] = 1;
                        if (i == Z_AXIS && bend) begin
                            zd = 1;
                            run = 0;
                        end
                    end
                end
                if (reached == 5'h1F) run = 0;
            end
        endcase
        r.pulses = pulses; r.dirs = dirs; r.reached = reached;
        r.run = run; r.zd = zd; r.pos = ok ? posn[ax] : 32'd0;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx <= REG_SPM_B) spm[idx] = val;
        else if (idx == REG_POLARITY) pol = val[4:0];
        else if (idx == REG_BEND) bend = val[0];
    endtask

    // send one request, honoring the idle rate; valid stays up between requests
    task automatic send_request(logic [1:0] act, logic [2:0] ax, logic [31:0] v,
                                bit known, t_levels lv);
        t_levels e;
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
            while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {3'b0, v, ax, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        e = step_axes(act, ax, v);
        if (known && e != lv)
            $display("%0t table row disagrees with predictor exp=%h got=%h", $time, lv, e);
        expected_levels.push_back(known ? lv : e);
    endtask

    // receiver side: stall pattern, checking
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            t_levels got, e;
            got = m_axis_tdata[48:0];
            results_seen++;
            if (expected_levels.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                e = expected_levels.pop_front();
                if (got != e) begin
                    $display("%0t mismatch exp pulse=%h dir=%h reach=%h run=%b z=%b pos=%h",
                             $time, e.pulses, e.dirs, e.reached, e.run, e.zd, e.pos);
                    $display("%0t          got pulse=%h dir=%h reach=%h run=%b z=%b pos=%h",
                             $time, got.pulses, got.dirs, got.reached, got.run, got.zd,
                             got.pos);
                    errors++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
    end

    task automatic drain;
        s_axis_tvalid <= 0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // random request with bias toward well-formed moves
    task automatic random_request(int spread);
        logic [1:0] act;
        logic [2:0] ax;
        logic [31:0] v;
        int k;
        t_levels none;
        none = '0;
        k = $urandom_range(99);
        act = k < 15 ? ACT_LOAD_TGT : k < 25 ? ACT_LOAD_POS : k < 30 ? ACT_START : ACT_TICK;
        ax = $urandom_range(99) < 92 ? 3'($urandom_range(4)) : 3'($urandom_range(7));
        if ($urandom_range(9) == 0) v = $urandom;
        else v = 32'($signed($urandom_range(2 * spread)) - spread);
        send_request(act, ax, v, 0, none);
    endtask

    t_row table_rows [$];

    task automatic add_row(logic [1:0] a, logic [2:0] x, logic [31:0] v, bit k,
                           t_levels lv);
        t_row r;
        r.act = a; r.ax = x; r.val = v; r.known = k; r.lv = lv;
        table_rows.push_back(r);
    endtask

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_levels z;
        int phase;
        z = '0;
        for (int i = 0; i < 5; i++) begin
            spm[i] = SPM_RESET; tgt[i] = 0; posn[i] = 0; inc[i] = 0; lim[i] = 0; cnt[i] = 0;
        end
        pol = POL_RESET; bend = 0;
        pulses = 0; dirs = 0; reached = 0; run = 0; zd = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed table: reset state, extremes, bad axis, idle tick, saturation
        add_row(ACT_TICK, 3'd0, 32'd0, 1, z);
        add_row(ACT_LOAD_POS, 3'd7, 32'hFFFFFFFF, 1, z);
        add_row(ACT_LOAD_TGT, 3'd5, 32'h12345678, 1, z);
        add_row(ACT_LOAD_POS, 3'd1, 32'h7FFFFFFF, 1, '{pos:32'h7FFFFFFF, default:0});
        add_row(ACT_LOAD_TGT, 3'd1, 32'h80000000, 0, z);
        add_row(ACT_LOAD_POS, 3'd4, 32'h80000000, 0, z);
        add_row(ACT_LOAD_TGT, 3'd4, 32'h7FFFFFFF, 0, z);
        add_row(ACT_LOAD_TGT, 3'd0, 32'h00020000, 0, z);
        add_row(ACT_LOAD_TGT, 3'd2, 32'hFFFF0000, 0, z);
        add_row(ACT_START, 3'd0, 32'd0, 0, z);
        for (int i = 0; i < 6; i++) add_row(ACT_TICK, 3'(i % 5), 32'd0, 0, z);
        add_row(ACT_LOAD_POS, 3'd0, 32'h00050000, 0, z);
        add_row(ACT_START, 3'd6, 32'd0, 0, z);
        add_row(ACT_TICK, 3'd3, 32'd0, 0, z);
        foreach (table_rows[i])
            send_request(table_rows[i].act, table_rows[i].ax, table_rows[i].val,
                         table_rows[i].known, table_rows[i].lv);
        drain();

        // back pressure: long hold while requests keep coming
        hold_off = 300;
        for (int i = 0; i < 20; i++) random_request(8 << 16);
        drain();

        // settings phases, including the extremes of every register
        for (phase = 0; phase < 8; phase++) begin
            for (int a = 0; a < 5; a++) begin
                case (phase)
                    0: write_reg(3'(a), 24'hFFFFFF);
                    1: write_reg(3'(a), 24'd1);
                    2: write_reg(3'(a), 24'd0);
                    default: write_reg(3'(a), 24'($urandom_range(4096, 1)));
                endcase
            end
            write_reg(REG_POLARITY, phase == 0 ? 24'd31 : phase == 1 ? 24'd0 :
                      24'($urandom_range(31)));
            write_reg(REG_BEND, 24'(phase % 2));
            send_idle = (phase % 4 == 1 || phase % 4 == 3) ? 87 : 0;
            recv_stall = (phase % 4 == 2) ? 87 : (phase % 4 == 3) ? 26 : 0;
            if (phase % 4 == 3) send_idle = 26;
            for (int i = 0; i < 125; i++)
                random_request(phase < 2 ? (1 << 12) : (4 << 16));
            drain();
        end

        $display("covered %0d results over 8 setting phases with idle, stall and hold-off",
                 results_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/mspg_pkg.sv
rtl/core/mspg_div.sv
rtl/core/mspg_ctrl.sv
rtl/core/mspg_dp.sv
rtl/core/multi_axis_step_pulse_generator.sv
dv/multi_axis_step_pulse_generator_test.sv
